@@ rtl/core/stku_pkg.sv @@
// Shared types and constants for the satellite table keyed update block.
// Used by stku_cell, stku_chain and satellite_table_keyed_update.
`default_nettype none

package stku_pkg;

    localparam int TBL_DEPTH   = 32;
    localparam int TBL_AW      = $clog2(TBL_DEPTH);
    localparam int TBL_CW      = $clog2(TBL_DEPTH + 1);
    localparam int OUT_CW      = 6;
    localparam int TIMER_W     = 16;
    localparam logic [TIMER_W-1:0] TIMER_MAX       = '1;
    localparam logic [TIMER_W-1:0] DEFAULT_TIMEOUT = 16'd15000;

    typedef enum logic [1:0] {
        CMD_REPORT = 2'd0,
        CMD_DONE   = 2'd1,
        CMD_TICK   = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    // Bit layout matches the stored word: sat_number in the low bits.
    typedef struct packed {
        logic [6:0] sig;
        logic [8:0] az;
        logic [6:0] el;
        logic [1:0] sys;
        logic [7:0] sat;
    } t_entry;

    // Query token that walks the chain of cells.
    typedef struct packed {
        logic              vld;
        t_cmd              cmd;
        t_entry            ent;
        logic [4:0]        idx;
        logic [TBL_CW-1:0] pos;
        logic              found;
        logic              app;
        logic              rvld;
        t_entry            rd;
    } t_stk;

endpackage

`default_nettype wire

@@ rtl/core/satellite_table_keyed_update.sv @@
// Top level of the satellite table: input/output stages, counts and timer.
// Depends on stku_pkg and stku_chain (which holds the stku_cell row).
//
//  channel  | direction | tuser            | tdata
//  ---------+-----------+------------------+----------------------------------------
//  s (in)   | item in   | command          | sat, sys, elev, azim, signal, entry_index
//  m (out)  | item out  | read_valid       | counts, read entry fields, report_dropped
//  cfg      | write     | -                | silence_timeout_ms
//
// A report or read item goes from the head register through the row of
// TBL_DEPTH cells, one cell per cycle, into the finished register and then the
// output register. Message-complete and tick items skip the row of cells.
// One item is in work at a time; the next is accepted once the previous has
// moved into the output register, even while that result waits to be taken.
// Reset (synchronous, active low) empties the table, zeroes the timer and
// loads the default timeout. Entry contents are left unreset.
`default_nettype none

module satellite_table_keyed_update
    import stku_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // slave item channel
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [39:0] i_s_tdata,   // sat_number[7:0], system_id[9:8],
                                          // elevation_deg[16:10], azimuth_deg[25:17],
                                          // signal_db[32:26], entry_index[37:33]
    input  wire logic [1:0]  i_s_tuser,   // command[1:0]
    // master item channel
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [63:0]      o_m_tdata,   // entry_count[5:0], count_gps[11:6],
                                          // count_glonass[17:12], count_beidou[23:18],
                                          // count_qzss[29:24], read_sat_number[37:30],
                                          // read_system_id[39:38], read_elevation[46:40],
                                          // read_azimuth[55:47], read_signal[62:56],
                                          // report_dropped[63]
    output logic [0:0]       o_m_tuser,   // read_valid[0]
    // configuration
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata  // silence_timeout_ms
);

    // ---- state ----
    logic               r_busy;       // token walking the cell row
    t_stk               r_head;       // token register feeding cell 0
    t_stk               r_fin;        // finished item waiting to retire
    logic [TBL_CW-1:0]  r_count;
    logic [TBL_CW-1:0]  r_cnt_sys [0:3];
    logic [TIMER_W-1:0] r_elapsed;
    logic [TIMER_W-1:0] r_timeout;
    logic               r_m_valid;
    logic [63:0]        r_m_data;
    logic [0:0]         r_m_user;

    t_stk               w_exit;
    t_stk               w_new;
    logic               w_accept;
    logic               w_chain_cmd;
    logic               w_retire;

    // next-state values computed at retire
    logic [TBL_CW-1:0]  n_count;
    logic [TBL_CW-1:0]  n_cnt_sys [0:3];
    logic [TIMER_W-1:0] n_elapsed;
    logic               n_dropped;
    logic [TIMER_W-1:0] w_tick_val;

    // ---- input stage ----
    // Take a new item only with the row empty and no finished item held.
    assign o_s_tready  = !r_busy && !r_fin.vld;
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign w_chain_cmd = (t_cmd'(i_s_tuser) == CMD_REPORT) || (t_cmd'(i_s_tuser) == CMD_READ);

    always_comb begin
        w_new.vld   = 1'b1;
        w_new.cmd   = t_cmd'(i_s_tuser);
        w_new.ent   = t_entry'(i_s_tdata[32:0]);
        w_new.idx   = i_s_tdata[37:33];
        w_new.pos   = '0;
        w_new.found = 1'b0;
        w_new.app   = 1'b0;
        w_new.rvld  = 1'b0;
        w_new.rd    = '0;
    end

    stku_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tok   (r_head),
        .i_count (r_count),
        .o_tok   (w_exit)
    );

    // ---- retire: apply counts and timer, fill the output register ----
    assign w_retire   = r_fin.vld && (!r_m_valid || i_m_tready);
    assign w_tick_val = (r_elapsed < TIMER_MAX) ? r_elapsed + TIMER_W'(1) : r_elapsed;

    always_comb begin
        n_count   = r_count;
        n_cnt_sys = r_cnt_sys;
        n_elapsed = r_elapsed;
        n_dropped = 1'b0;
        unique case (r_fin.cmd)
            CMD_REPORT: begin
                if (r_fin.app) begin
                    n_count = r_count + TBL_CW'(1);
                    n_cnt_sys[r_fin.ent.sys] = r_cnt_sys[r_fin.ent.sys] + TBL_CW'(1);
                end
                // New key and no free cell: drop the report
                n_dropped = !r_fin.found && !r_fin.app;
            end
            CMD_DONE: begin
                n_elapsed = '0;
            end
            CMD_TICK: begin
                n_elapsed = w_tick_val;
                // Silence timeout: empty the table, keep the timer running
                if (w_tick_val > r_timeout) begin
                    n_count   = '0;
                    n_cnt_sys = '{default: '0};
                end
            end
            CMD_READ: begin
                n_count = r_count;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // ---- control registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_count    <= '0;
            r_cnt_sys  <= '{default: '0};
            r_elapsed  <= '0;
            r_timeout  <= DEFAULT_TIMEOUT;
            r_m_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
            if (w_accept && w_chain_cmd) begin
                r_busy <= 1'b1;
            end else if (w_exit.vld) begin
                r_busy <= 1'b0;
            end
            if (w_retire) begin
                r_count   <= n_count;
                r_cnt_sys <= n_cnt_sys;
                r_elapsed <= n_elapsed;
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // ---- token registers ----
    always_ff @(posedge i_clk) begin
        // Launch search items into the row; the head holds a token for one cycle
        r_head.vld <= w_accept && w_chain_cmd;
        if (w_accept && !w_chain_cmd) begin
            r_fin.vld <= 1'b1;
        end else if (w_exit.vld) begin
            r_fin.vld <= 1'b1;
        end else if (w_retire) begin
            r_fin.vld <= 1'b0;
        end
        if (w_accept) begin
            r_head.cmd   <= w_new.cmd;
            r_head.ent   <= w_new.ent;
            r_head.idx   <= w_new.idx;
            r_head.pos   <= w_new.pos;
            r_head.found <= w_new.found;
            r_head.app   <= w_new.app;
            r_head.rvld  <= w_new.rvld;
            r_head.rd    <= w_new.rd;
        end
        if (w_accept && !w_chain_cmd) begin
            r_fin.cmd   <= w_new.cmd;
            r_fin.ent   <= w_new.ent;
            r_fin.idx   <= w_new.idx;
            r_fin.pos   <= w_new.pos;
            r_fin.found <= w_new.found;
            r_fin.app   <= w_new.app;
            r_fin.rvld  <= w_new.rvld;
            r_fin.rd    <= w_new.rd;
        end else if (w_exit.vld) begin
            r_fin.cmd   <= w_exit.cmd;
            r_fin.ent   <= w_exit.ent;
            r_fin.idx   <= w_exit.idx;
            r_fin.pos   <= w_exit.pos;
            r_fin.found <= w_exit.found;
            r_fin.app   <= w_exit.app;
            r_fin.rvld  <= w_exit.rvld;
            r_fin.rd    <= w_exit.rd;
        end
        // Reset clears only the valid bits; the payload follows them
        if (!i_rst_n) begin
            r_head.vld <= 1'b0;
            r_fin.vld  <= 1'b0;
        end
    end

    // ---- output payload ----
    always_ff @(posedge i_clk) begin
        if (w_retire) begin
            r_m_data <= {n_dropped, r_fin.rd,
                         OUT_CW'(n_cnt_sys[3]), OUT_CW'(n_cnt_sys[2]),
                         OUT_CW'(n_cnt_sys[1]), OUT_CW'(n_cnt_sys[0]),
                         OUT_CW'(n_count)};
            r_m_user <= r_fin.rvld;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;

    // ---- assertions ----
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= TBL_CW'(TBL_DEPTH))
        else $error("entry count above table depth");

    a_count_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((TBL_CW+2)'(r_cnt_sys[0]) + (TBL_CW+2)'(r_cnt_sys[1])
         + (TBL_CW+2)'(r_cnt_sys[2]) + (TBL_CW+2)'(r_cnt_sys[3]))
        == (TBL_CW+2)'(r_count))
        else $error("per-system counts disagree with entry count");

    a_exit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exit.vld |-> r_busy && !r_fin.vld)
        else $error("token left the cell row with no search in work");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_m_data[63]) |-> (r_count == TBL_CW'(TBL_DEPTH)))
        else $error("report dropped with room left in the table");

endmodule

`default_nettype wire

@@ rtl/core/stku_cell.sv @@
// One table cell: holds a single entry and hands the query token onward.
// Depends on stku_pkg.
`default_nettype none

module stku_cell
    import stku_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_stk              i_tok,
    input  wire logic [TBL_CW-1:0] i_count,
    output t_stk                   o_tok
);

    t_entry r_entry;
    t_stk   r_tok;
    t_stk   n_tok;
    logic   w_hit;
    logic   w_app;
    logic   w_rd;

    always_comb begin
        w_hit = i_tok.vld && (i_tok.cmd == CMD_REPORT) && !i_tok.found
                && (i_tok.pos < i_count)
                && (r_entry.sat == i_tok.ent.sat) && (r_entry.sys == i_tok.ent.sys);
        // First free slot: the token has passed every valid entry without a match
        w_app = i_tok.vld && (i_tok.cmd == CMD_REPORT) && !i_tok.found
                && (i_tok.pos == i_count);
        w_rd  = i_tok.vld && (i_tok.cmd == CMD_READ) && (i_tok.pos < i_count)
                && (i_tok.pos == TBL_CW'(i_tok.idx));
        n_tok       = i_tok;
        n_tok.pos   = i_tok.pos + TBL_CW'(1);
        n_tok.found = i_tok.found | w_hit;
        n_tok.app   = i_tok.app | w_app;
        if (w_rd) begin
            n_tok.rvld = 1'b1;
            n_tok.rd   = r_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_hit || w_app) begin
            r_entry <= i_tok.ent;
        end
    end

    // Advance the token every cycle; reset clears only its valid bit.
    always_ff @(posedge i_clk) begin
        r_tok <= n_tok;
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

@@ rtl/core/stku_chain.sv @@
// Row of TBL_DEPTH table cells; the token enters cell 0 and leaves the last.
// Depends on stku_pkg and stku_cell.
`default_nettype none

module stku_chain
    import stku_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_stk              i_tok,
    input  wire logic [TBL_CW-1:0] i_count,
    output t_stk                   o_tok
);

    t_stk w_tok [0:TBL_DEPTH];

    assign w_tok[0] = i_tok;

    for (genvar g = 0; g < TBL_DEPTH; g++) begin : g_cell
        stku_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_tok[g]),
            .i_count (i_count),
            .o_tok   (w_tok[g+1])
        );
    end

    assign o_tok = w_tok[TBL_DEPTH];

endmodule

`default_nettype wire

@@ dv/tb_satellite_table_keyed_update.sv @@
`timescale 1ns / 100ps
// Self-checking bench for satellite_table_keyed_update: keyed report updates, silence
// timeout clearing, reads and per-constellation counts, checked on every result item.
// Depends on stku_pkg and the block's RTL only.

module tb_satellite_table_keyed_update;
    import stku_pkg::*;

    // One input item, as the bench sees it before packing onto the bus.
    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] sat;
        logic [1:0] sys;
        logic [6:0] el;
        logic [8:0] az;
        logic [6:0] sig;
        logic [4:0] idx;
    } t_sat_item;

    // One result item: table counts plus the read-back entry.
    typedef struct packed {
        logic [OUT_CW-1:0] n_entries;
        logic [OUT_CW-1:0] n_gps;
        logic [OUT_CW-1:0] n_glonass;
        logic [OUT_CW-1:0] n_beidou;
        logic [OUT_CW-1:0] n_qzss;
        logic              rd_valid;
        t_entry            rd;
        logic              dropped;
    } t_sat_view;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [39:0] i_s_tdata   = '0;      // sat_number, system_id, elevation_deg,
                                        // azimuth_deg, signal_db, entry_index
    logic [1:0]  i_s_tuser   = CMD_REPORT;  // command
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [63:0] o_m_tdata;             // entry_count, count_gps, count_glonass,
                                        // count_beidou, count_qzss, read_sat_number,
                                        // read_system_id, read_elevation, read_azimuth,
                                        // read_signal, report_dropped
    logic [0:0]  o_m_tuser;             // read_valid
    logic        i_cfg_we    = 1'b0;
    logic [15:0] i_cfg_wdata = '0;      // silence_timeout_ms

    satellite_table_keyed_update u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shadow of the satellite table
    // ------------------------------------------------------------------
    t_entry             entry_tbl [TBL_DEPTH];
    int unsigned        tbl_count    = 0;
    int unsigned        sys_count [4] = '{default: 0};
    int unsigned        silence_ms   = 0;
    logic [TIMER_W-1:0] timeout_ms   = DEFAULT_TIMEOUT;
    // Highest position ever written; reads stay below it so that no
    // never-written entry is touched.
    int unsigned        written_mark = 0;

    t_sat_item pending_items [$];
    t_sat_view expected_views [$];
    t_sat_item bus_item;
    bit        item_taken    = 1'b0;
    int unsigned src_idle_pct = 10;
    int unsigned snk_idle_pct = 49;
    int unsigned n_fail       = 0;

    // Append to the tail of the pending and expected queues.
    task automatic queue_item(t_sat_item it);
        pending_items = {pending_items, it};
    endtask

    task automatic queue_view(t_sat_view v);
        expected_views = {expected_views, v};
    endtask

    // Apply one item to the shadow table and return the result it yields.
    function automatic t_sat_view predict_view(t_sat_item it);
        t_sat_view v;
        t_entry    ent;
        bit        hit;
        v   = '0;
        ent = {it.sig, it.az, it.el, it.sys, it.sat};
        hit = 1'b0;
        case (it.cmd)
            CMD_REPORT: begin
                // Replace the first entry with the same key, else append.
                for (int i = 0; i < tbl_count; i++) begin
                    if (!hit && entry_tbl[i].sat == it.sat && entry_tbl[i].sys == it.sys) begin
                        entry_tbl[i] = ent;
                        hit = 1'b1;
                    end
                end
                if (!hit) begin
                    if (tbl_count < TBL_DEPTH) begin
                        entry_tbl[tbl_count] = ent;
                        tbl_count++;
                        sys_count[it.sys]++;
                        if (tbl_count > written_mark)
                            written_mark = tbl_count;
                    end else begin
                        v.dropped = 1'b1;
                    end
                end
            end
            CMD_DONE: silence_ms = 0;
            CMD_TICK: begin
                // Saturate the timer; clearing drops the counts only.
                if (silence_ms < TIMER_MAX)
                    silence_ms++;
                if (silence_ms > timeout_ms && tbl_count != 0) begin
                    tbl_count = 0;
                    sys_count = '{default: 0};
                end
            end
            default: begin
                if (it.idx < tbl_count) begin
                    v.rd_valid = 1'b1;
                    v.rd       = entry_tbl[it.idx];
                end
            end
        endcase
        v.n_entries = OUT_CW'(tbl_count);
        v.n_gps     = OUT_CW'(sys_count[0]);
        v.n_glonass = OUT_CW'(sys_count[1]);
        v.n_beidou  = OUT_CW'(sys_count[2]);
        v.n_qzss    = OUT_CW'(sys_count[3]);
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Item builders
    // ------------------------------------------------------------------
    function automatic t_sat_item mk(t_cmd c, logic [7:0] sat, logic [1:0] sys,
                                     logic [6:0] el, logic [8:0] az, logic [6:0] sig,
                                     logic [4:0] idx);
        t_sat_item it;
        it = '{cmd: c, sat: sat, sys: sys, el: el, az: az, sig: sig, idx: idx};
        return it;
    endfunction

    // Random payload. Half the satellite numbers come from a small pool so
    // that keys repeat and reports hit the replace path.
    function automatic t_sat_item rand_fields();
        t_sat_item it;
        it.cmd = CMD_REPORT;
        it.sat = ($urandom_range(99) < 50) ? 8'($urandom_range(11)) : 8'($urandom_range(255));
        it.sys = 2'($urandom_range(3));
        // Mostly legal angles and levels, now and then anything the width holds.
        it.el  = ($urandom_range(99) < 5) ? 7'($urandom_range(127)) : 7'($urandom_range(90));
        it.az  = ($urandom_range(99) < 5) ? 9'($urandom_range(511)) : 9'($urandom_range(359));
        it.sig = ($urandom_range(99) < 5) ? 7'($urandom_range(127)) : 7'($urandom_range(99));
        it.idx = 5'($urandom_range(31));
        return it;
    endfunction

    function automatic t_sat_item rand_item(int unsigned tick_pct);
        t_sat_item   it;
        int unsigned r;
        it = rand_fields();
        r  = $urandom_range(99);
        if (r < tick_pct)
            it.cmd = CMD_TICK;
        else if (r < tick_pct + 10)
            it.cmd = CMD_DONE;
        else if (r < tick_pct + 30)
            it.cmd = CMD_READ;
        return it;
    endfunction

    // Episodes of mixed traffic, each now and then followed by a silent run
    // of ticks long enough to clear the table. Stop at exactly n_items.
    task automatic run_random(int unsigned n_items, int unsigned tick_pct,
                              int unsigned burst_len);
        int unsigned made;
        int unsigned ep;
        t_sat_item   it;
        made = 0;
        while (made < n_items) begin
            ep = $urandom_range(70, 8);
            repeat (ep) begin
                if (made < n_items) begin
                    queue_item(rand_item(tick_pct));
                    made++;
                end
            end
            if (burst_len != 0 && $urandom_range(1) == 1) begin
                repeat (burst_len) begin
                    if (made < n_items) begin
                        it     = rand_fields();
                        it.cmd = CMD_TICK;
                        queue_item(it);
                        made++;
                    end
                end
            end
        end
    endtask

    // Hold until every queued item went in and every result came back.
    task automatic wait_idle();
        do
            @(posedge i_clk);
        while (pending_items.size() != 0 || i_s_tvalid || item_taken ||
               expected_views.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_timeout(logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            n_fail++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // Input side: note acceptance at the rising edge, predict and drive at
    // the falling edge so that pushes and pops never share a time step.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : accept_sampler
        if (i_rst_n && i_s_tvalid && o_s_tready)
            item_taken = 1'b1;
        // A new timeout lands in the shadow at the same edge as in the block.
        if (i_rst_n && i_cfg_we)
            timeout_ms = i_cfg_wdata;
    end

    always @(negedge i_clk) begin : item_driver
        t_sat_item nxt;
        if (item_taken)
            queue_view(predict_view(bus_item));
        // Hold the current item until taken; then advance or idle.
        if (!i_s_tvalid || item_taken) begin
            item_taken = 1'b0;
            if (pending_items.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                nxt = pending_items.pop_front();
                // Fold a read index onto positions that have been written.
                if (nxt.cmd == CMD_READ && written_mark != 0 && nxt.idx >= written_mark)
                    nxt.idx = 5'(nxt.idx % written_mark);
                bus_item   = nxt;
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= {2'b00, nxt.idx, nxt.sig, nxt.az, nxt.el, nxt.sys, nxt.sat};
                i_s_tuser  <= nxt.cmd;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
        i_m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // ------------------------------------------------------------------
    // Output side: compare each result item with the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        t_sat_view want;
        t_entry    got_rd;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_views.size() == 0) begin
                n_fail++;
                $error("result item with no prediction waiting");
            end else begin
                want   = expected_views.pop_front();
                got_rd = o_m_tdata[62:30];
                check_field("entry_count",     32'(want.n_entries), 32'(o_m_tdata[5:0]));
                check_field("count_gps",       32'(want.n_gps),     32'(o_m_tdata[11:6]));
                check_field("count_glonass",   32'(want.n_glonass), 32'(o_m_tdata[17:12]));
                check_field("count_beidou",    32'(want.n_beidou),  32'(o_m_tdata[23:18]));
                check_field("count_qzss",      32'(want.n_qzss),    32'(o_m_tdata[29:24]));
                check_field("read_valid",      32'(want.rd_valid),  32'(o_m_tuser[0]));
                check_field("read_sat_number", 32'(want.rd.sat),    32'(got_rd.sat));
                check_field("read_system_id",  32'(want.rd.sys),    32'(got_rd.sys));
                check_field("read_elevation",  32'(want.rd.el),     32'(got_rd.el));
                check_field("read_azimuth",    32'(want.rd.az),     32'(got_rd.az));
                check_field("read_signal",     32'(want.rd.sig),    32'(got_rd.sig));
                check_field("report_dropped",  32'(want.dropped),   32'(o_m_tdata[63]));
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Short timeout so the directed part can show clearing in a few ticks.
        set_timeout(16'd2);

        // Field extremes, same number in two constellations, out-of-range
        // report values, then a replace of an existing key.
        queue_item(mk(CMD_REPORT, 8'd0,   2'd0, 7'd0,   9'd0,   7'd0,   5'd0));
        queue_item(mk(CMD_REPORT, 8'd255, 2'd3, 7'd90,  9'd359, 7'd99,  5'd31));
        queue_item(mk(CMD_REPORT, 8'd255, 2'd2, 7'd45,  9'd180, 7'd0,   5'd0));
        queue_item(mk(CMD_REPORT, 8'd1,   2'd1, 7'd127, 9'd511, 7'd127, 5'd31));
        queue_item(mk(CMD_REPORT, 8'd255, 2'd3, 7'd10,  9'd20,  7'd30,  5'd0));
        for (int i = 0; i < 4; i++)
            queue_item(mk(CMD_READ, 8'd255, 2'd3, 7'd127, 9'd511, 7'd127, 5'(i)));
        // Restart the timer, then two ticks stay within the timeout and the
        // third clears the table.
        queue_item(mk(CMD_DONE, 8'd0, 2'd0, 7'd0, 9'd0, 7'd0, 5'd0));
        repeat (3)
            queue_item(mk(CMD_TICK, 8'd255, 2'd3, 7'd127, 9'd511, 7'd127, 5'd31));
        // Read past the count at a position that was written before.
        queue_item(mk(CMD_READ, 8'd0, 2'd0, 7'd0, 9'd0, 7'd0, 5'd3));
        // Timer keeps running while empty: a fresh entry goes on the next tick
        // until a message completes.
        queue_item(mk(CMD_TICK,   8'd0, 2'd0, 7'd0,  9'd0,  7'd0,  5'd0));
        queue_item(mk(CMD_REPORT, 8'd7, 2'd0, 7'd33, 9'd99, 7'd40, 5'd0));
        queue_item(mk(CMD_TICK,   8'd0, 2'd0, 7'd0,  9'd0,  7'd0,  5'd0));
        queue_item(mk(CMD_DONE,   8'd0, 2'd0, 7'd0,  9'd0,  7'd0,  5'd0));
        queue_item(mk(CMD_REPORT, 8'd7, 2'd0, 7'd33, 9'd99, 7'd40, 5'd0));
        queue_item(mk(CMD_TICK,   8'd0, 2'd0, 7'd0,  9'd0,  7'd0,  5'd0));
        queue_item(mk(CMD_READ,   8'd0, 2'd0, 7'd0,  9'd0,  7'd0,  5'd0));

        // Sender idles lightly, receiver stalls about half the time.
        run_random(160, 5, 41);
        wait_idle();
        set_timeout(16'd40);
        run_random(40, 5, 41);

        // Swap the idling; zero timeout clears on any tick with time elapsed.
        wait_idle();
        src_idle_pct = 49;
        snk_idle_pct = 10;
        set_timeout(16'd0);
        run_random(170, 2, 1);

        // No idling; largest timeout never clears, so the table fills and
        // new keys get dropped.
        wait_idle();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        set_timeout(16'hFFFF);
        run_random(170, 8, 0);

        // At the top timeout ticks never clear the table.
        wait_idle();
        queue_item(mk(CMD_REPORT, 8'd9, 2'd2, 7'd12, 9'd34, 7'd56, 5'd0));
        queue_item(mk(CMD_TICK,   8'd0, 2'd0, 7'd0,  9'd0,  7'd0,  5'd0));
        queue_item(mk(CMD_READ,   8'd0, 2'd0, 7'd0,  9'd0,  7'd0,  5'd0));

        // Drain, then allow the longest item latency for stray results.
        wait_idle();
        repeat (40) @(posedge i_clk);
        if (n_fail == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog: several times the slowest correct run.
    initial begin : watchdog
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
